>>> rtl/core/hcmg_pkg.sv
// Shared types, constants and helper functions for the HLS color mask core.
// Used by hls_color_mask_gray_core; depends on nothing else.
`timescale 1ns / 1ps

package hcmg_pkg;

  localparam int unsigned NUM_STAGES  = 9;
  localparam int unsigned DIV_STAGES  = 4;
  localparam int unsigned CFG_AW      = 2;
  localparam int unsigned CFG_DW      = 24;
  localparam int unsigned PIX_DW      = 24;
  localparam int unsigned OUT_DW      = 32;
  localparam int unsigned OUT_UW      = 3;

  localparam logic [CFG_DW-1:0] WHITE_LOW_RST   = 24'h00C832;
  localparam logic [CFG_DW-1:0] WHITE_HIGH_RST  = 24'hB4FF64;
  localparam logic [CFG_DW-1:0] YELLOW_LOW_RST  = 24'h1E961E;
  localparam logic [CFG_DW-1:0] YELLOW_HIGH_RST = 24'h32C85A;

  localparam logic [15:0] LUMA_R    = 16'd19595;
  localparam logic [15:0] LUMA_G    = 16'd38470;
  localparam logic [15:0] LUMA_B    = 16'd7471;
  localparam logic [23:0] LUMA_RND  = 24'd32768;
  localparam logic [7:0]  HUE_MAX   = 8'd180;
  localparam logic [8:0]  SUM_SPLIT = 9'd255;
  localparam logic [9:0]  SUM_FULL  = 10'd510;

  typedef enum logic [CFG_AW-1:0] {
    REG_WHITE_LOW   = 2'd0,
    REG_WHITE_HIGH  = 2'd1,
    REG_YELLOW_LOW  = 2'd2,
    REG_YELLOW_HIGH = 2'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    SECT_RED   = 2'd0,
    SECT_GREEN = 2'd1,
    SECT_BLUE  = 2'd2
  } hue_sect_e;

  typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic        eof;
  } pix_t;

  typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  mx;
    logic [7:0]  mn;
    hue_sect_e   sect;
    logic [22:0] prod_r;
    logic [23:0] prod_g;
    logic [20:0] prod_b;
    logic        eof;
  } ext_t;

  typedef struct packed {
    logic [7:0]  d;
    logic [7:0]  den;
    logic [10:0] num;
    logic [7:0]  light;
    logic [7:0]  gray;
    logic        eof;
  } sect_t;

  typedef struct packed {
    logic [16:0] rem;
    logic [7:0]  quo;
  } div_t;

  typedef struct packed {
    div_t        sat;
    div_t        hue;
    logic [8:0]  sat_dv;
    logic [8:0]  hue_dv;
    logic        zero;
    logic [7:0]  light;
    logic [7:0]  gray;
    logic        eof;
  } div_pipe_t;

  // One restoring division step: tries the divisor shifted to the given bit.
  function automatic div_t div_step(div_t st, logic [8:0] dv, logic [2:0] bit_idx);
    logic [16:0] sh;
    div_t        res;
    sh = 17'(dv) << bit_idx;
    if (st.rem >= sh) begin
      res.rem = st.rem - sh;
      res.quo = {st.quo[6:0], 1'b1};
    end else begin
      res.rem = st.rem;
      res.quo = {st.quo[6:0], 1'b0};
    end
    return res;
  endfunction

  // Inclusive test of an HLS triple against a packed box.
  function automatic logic in_box(logic [7:0] h, logic [7:0] l, logic [7:0] s,
                                  logic [CFG_DW-1:0] lo, logic [CFG_DW-1:0] hi);
    return (h >= lo[7:0])   && (h <= hi[7:0])   &&
           (l >= lo[15:8])  && (l <= hi[15:8])  &&
           (s >= lo[23:16]) && (s <= hi[23:16]);
  endfunction

endpackage

>>> rtl/core/hls_color_mask_gray_core.sv
// Pipelined BGR to HLS conversion, white/yellow box test and masked gray level.
// Depends on hcmg_pkg for types, constants and the divider step.
// Throughput: one pixel per cycle unless the output stalls; two 8-bit quotients are
// formed two bits per stage over four divider stages, each stage holding its own pixel.
// Every stage stalls only when it holds data and the stage after it is full.
// Reset clears all stage valid bits and loads the default white and yellow boxes.
`timescale 1ns / 1ps

module hls_color_mask_gray_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_wr_en_i,
  input  logic [hcmg_pkg::CFG_AW-1:0]    cfg_addr_i,
  input  logic [hcmg_pkg::CFG_DW-1:0]    cfg_wdata_i,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // Fields from bit 0: blue[7:0], green[15:8], red[23:16].
  input  logic [hcmg_pkg::PIX_DW-1:0]    s_axis_tdata,
  input  logic                           s_axis_tlast,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // Fields from bit 0: hue[7:0], lightness[15:8], saturation[23:16], gray_level[31:24].
  output logic [hcmg_pkg::OUT_DW-1:0]    m_axis_tdata,
  // Fields from bit 0: is_white[0], is_yellow[1], color_mask[2].
  output logic [hcmg_pkg::OUT_UW-1:0]    m_axis_tuser,
  output logic                           m_axis_tlast
);

  import hcmg_pkg::*;

  logic [CFG_DW-1:0] white_low_q, white_high_q, yellow_low_q, yellow_high_q;

  logic [NUM_STAGES-1:0] vld_q;
  logic [NUM_STAGES:0]   rdy;

  pix_t       pix_q;
  ext_t       ext_q;
  sect_t      sect_q;
  div_pipe_t  dpipe_q [DIV_STAGES+1];
  logic [OUT_DW-1:0] out_data_q;
  logic [OUT_UW-1:0] out_user_q;
  logic              out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      white_low_q   <= WHITE_LOW_RST;
      white_high_q  <= WHITE_HIGH_RST;
      yellow_low_q  <= YELLOW_LOW_RST;
      yellow_high_q <= YELLOW_HIGH_RST;
    end else if (cfg_wr_en_i) begin
      case (cfg_reg_e'(cfg_addr_i))
        REG_WHITE_LOW:   white_low_q   <= cfg_wdata_i;
        REG_WHITE_HIGH:  white_high_q  <= cfg_wdata_i;
        REG_YELLOW_LOW:  yellow_low_q  <= cfg_wdata_i;
        REG_YELLOW_HIGH: yellow_high_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // A stage can take new data when it is empty or its content moves on.
  always_comb begin
    rdy[NUM_STAGES] = m_axis_tready;
    for (int k = NUM_STAGES - 1; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
  end
  assign s_axis_tready = rdy[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (rdy[0]) begin
        vld_q[0] <= s_axis_tvalid;
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (rdy[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  // Stage 1: input register.
  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      pix_q.blue  <= s_axis_tdata[7:0];
      pix_q.green <= s_axis_tdata[15:8];
      pix_q.red   <= s_axis_tdata[23:16];
      pix_q.eof   <= s_axis_tlast;
    end
  end

  // Stage 2: extremes, hue sector and luma products.
  ext_t ext_d;
  always_comb begin
    logic [7:0] mx, mn;
    mx = pix_q.red;
    if (pix_q.green > mx) mx = pix_q.green;
    if (pix_q.blue > mx)  mx = pix_q.blue;
    mn = pix_q.red;
    if (pix_q.green < mn) mn = pix_q.green;
    if (pix_q.blue < mn)  mn = pix_q.blue;
    ext_d.red    = pix_q.red;
    ext_d.green  = pix_q.green;
    ext_d.blue   = pix_q.blue;
    ext_d.mx     = mx;
    ext_d.mn     = mn;
    if (mx == pix_q.red) begin
      ext_d.sect = SECT_RED;
    end else if (mx == pix_q.green) begin
      ext_d.sect = SECT_GREEN;
    end else begin
      ext_d.sect = SECT_BLUE;
    end
    ext_d.prod_r = 23'(LUMA_R[14:0]) * 23'(pix_q.red);
    ext_d.prod_g = LUMA_G * pix_q.green;
    ext_d.prod_b = 21'(LUMA_B[12:0]) * 21'(pix_q.blue);
    ext_d.eof    = pix_q.eof;
  end

  always_ff @(posedge clk_i) begin
    if (rdy[1]) begin
      ext_q <= ext_d;
    end
  end

  // Stage 3: spread, lightness, saturation denominator, sector position, luma.
  sect_t sect_d;
  always_comb begin
    logic [7:0]  d;
    logic [8:0]  sum;
    logic [23:0] luma;
    d   = ext_q.mx - ext_q.mn;
    sum = 9'(ext_q.mx) + 9'(ext_q.mn);
    sect_d.d     = d;
    sect_d.light = 8'((10'(sum) + 10'd1) >> 1);
    sect_d.den   = (sum < SUM_SPLIT) ? sum[7:0] : 8'(SUM_FULL - 10'(sum));
    case (ext_q.sect)
      SECT_RED: begin
        if (ext_q.green >= ext_q.blue) begin
          sect_d.num = 11'(ext_q.green - ext_q.blue);
        end else begin
          sect_d.num = 11'({d, 2'b00}) + 11'({d, 1'b0}) - 11'(ext_q.blue - ext_q.green);
        end
      end
      SECT_GREEN: sect_d.num = 11'({d, 1'b0}) + 11'(ext_q.blue) - 11'(ext_q.red);
      SECT_BLUE:  sect_d.num = 11'({d, 2'b00}) + 11'(ext_q.red) - 11'(ext_q.green);
      default:    sect_d.num = '0;
    endcase
    luma = 24'(ext_q.prod_r) + ext_q.prod_g + 24'(ext_q.prod_b) + LUMA_RND;
    sect_d.gray = luma[23:16];
    sect_d.eof  = ext_q.eof;
  end

  always_ff @(posedge clk_i) begin
    if (rdy[2]) begin
      sect_q <= sect_d;
    end
  end

  // Stage 4: dividends and divisors for saturation and hue.
  div_pipe_t dpipe_d;
  always_comb begin
    dpipe_d.sat.rem = 17'({sect_q.d, 9'b0}) - 17'({sect_q.d, 1'b0}) + 17'(sect_q.den);
    dpipe_d.sat.quo = '0;
    dpipe_d.hue.rem = {sect_q.num, 6'b0} - 17'({sect_q.num, 2'b0}) + 17'(sect_q.d);
    dpipe_d.hue.quo = '0;
    dpipe_d.sat_dv  = {1'b0, sect_q.den} << 1;
    dpipe_d.hue_dv  = {1'b0, sect_q.d} << 1;
    dpipe_d.zero    = (sect_q.d == '0);
    dpipe_d.light   = sect_q.light;
    dpipe_d.gray    = sect_q.gray;
    dpipe_d.eof     = sect_q.eof;
  end

  // Stages 5 to 8: two quotient bits per stage, most significant first.
  div_pipe_t div_nxt [DIV_STAGES];
  always_comb begin
    for (int k = 0; k < DIV_STAGES; k++) begin
      div_nxt[k]     = dpipe_q[k];
      div_nxt[k].sat = div_step(div_step(dpipe_q[k].sat, dpipe_q[k].sat_dv, 3'(7 - 2 * k)),
                                dpipe_q[k].sat_dv, 3'(6 - 2 * k));
      div_nxt[k].hue = div_step(div_step(dpipe_q[k].hue, dpipe_q[k].hue_dv, 3'(7 - 2 * k)),
                                dpipe_q[k].hue_dv, 3'(6 - 2 * k));
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[3]) begin
      dpipe_q[0] <= dpipe_d;
    end
    for (int k = 0; k < DIV_STAGES; k++) begin
      if (rdy[4+k]) begin
        dpipe_q[k+1] <= div_nxt[k];
      end
    end
  end

  // Stage 9: clamp, box tests, masked gray and output register.
  always_ff @(posedge clk_i) begin
    logic [7:0] hue, sat;
    logic       white, yellow, mask;
    if (rdy[NUM_STAGES-1]) begin
      hue = (dpipe_q[DIV_STAGES].hue.quo > HUE_MAX) ? HUE_MAX : dpipe_q[DIV_STAGES].hue.quo;
      sat = dpipe_q[DIV_STAGES].sat.quo;
      if (dpipe_q[DIV_STAGES].zero) begin
        hue = '0;
        sat = '0;
      end
      white  = in_box(hue, dpipe_q[DIV_STAGES].light, sat, white_low_q, white_high_q);
      yellow = in_box(hue, dpipe_q[DIV_STAGES].light, sat, yellow_low_q, yellow_high_q);
      mask   = white || yellow;
      out_data_q <= {mask ? dpipe_q[DIV_STAGES].gray : 8'd0, sat,
                     dpipe_q[DIV_STAGES].light, hue};
      out_user_q <= {mask, yellow, white};
      out_last_q <= dpipe_q[DIV_STAGES].eof;
    end
  end

  assign m_axis_tvalid = vld_q[NUM_STAGES-1];
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;
  assign m_axis_tlast  = out_last_q;

  a_mask_or : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser[2] == (m_axis_tuser[0] || m_axis_tuser[1])))
    else $error("color mask does not match the box flags");

  a_gray_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser[2]) |-> (m_axis_tdata[31:24] == 8'd0))
    else $error("gray level set on an unmasked pixel");

  a_hue_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[7:0] <= HUE_MAX))
    else $error("hue beyond its range");

  a_gray_pixel : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tdata[23:16] == 8'd0)) |-> (m_axis_tdata[7:0] == 8'd0))
    else $error("hue set on a pixel without saturation");

  a_no_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tready |-> s_axis_tready)
    else $error("input stalled while the output side is ready");

endmodule
